[hdl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and helpers of the url percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;

	localparam int QUEUE_DEPTH_DEF = 4;

	// escape tracking in the front part
	typedef enum logic [2:0] {
		PH_PLAIN = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} upd_phase_t;

	// one command: up to two data bytes, then an optional terminator
	typedef struct packed {
		logic [1:0] n_data;
		logic       term;
		logic [7:0] b0;
		logic [7:0] b1;
	} upd_cmd_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} upd_qstat_t;

	// bit 4 set: not an upper-case hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, c[3:0]};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	function automatic logic [7:0] plain_map(input logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

endpackage

[hdl/url_percent_decoder_top.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Form-url decoder: '+' to space, %XY escapes to one byte, zero-terminated.
//
//  channel | dir | data                        | marker
//  s_*     | in  | tdata[7:0] encoded byte     | tlast ends the string
//  m_*     | out | tdata[7:0] decoded byte     | tlast on the zero terminator
//
// one input byte per cycle while the queue has room; a byte may yield up to
// three results, the queue absorbs the extra cycles; an accepted item passes
// the queue, then the output register, which gives one result per cycle unless
// m_tready stalls; s_tready drops while the queue is full, even when the back
// pops; arst_n clears the escape tracking, the queue and the output valid
// ----------------------------------------------------------------------------
module url_percent_decoder_top import upd_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	logic       accept;
	logic       push;
	logic       pop;
	upd_cmd_t   cmd;
	upd_cmd_t   head;
	upd_qstat_t qstat;

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	upd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_tdata),
		.in_last (s_tlast),
		.push    (push),
		.cmd     (cmd)
	);

	upd_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (qstat)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (qstat.head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	// the terminator is the only zero byte and always closes the run
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == CH_NUL)
		else $error("last result is not a zero byte");

	a_zero_term: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata == CH_NUL |-> m_tlast)
		else $error("zero byte without last");

	// no result appears unless a command was waiting
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.head_valid && !m_tvalid |=> !m_tvalid)
		else $error("result without a queued command");

	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qstat.head_valid)
		else $error("pop from an empty queue");

endmodule

[hdl/upd_front.sv]
// ----------------------------------------------------------------------------
// upd_front
// Accepts input bytes, tracks escapes and turns them into commands.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output upd_cmd_t   cmd
);

	upd_phase_t phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic       drop_q, drop_d;
	logic [4:0] hi, lo;
	logic [7:0] dec;
	logic       gen;

	assign hi  = hex_value(held_q);
	assign lo  = hex_value(in_byte);
	assign dec = (hi[4] || lo[4]) ? CH_NUL : {hi[3:0], lo[3:0]};

	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		drop_d  = drop_q;
		gen     = 1'b0;
		cmd     = '0;
		if (drop_q) begin
			if (in_last) begin
				drop_d = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_PCT: begin
					if (in_last) begin
						// short escape: '%' passes, the byte is plain text
						gen     = 1'b1;
						cmd.b0  = CH_PERCENT;
						cmd.term = 1'b1;
						phase_d = PH_PLAIN;
						if (in_byte == CH_NUL) begin
							cmd.n_data = 2'd1;
						end else begin
							cmd.n_data = 2'd2;
							cmd.b1     = plain_map(in_byte);
						end
					end else begin
						held_d  = in_byte;
						phase_d = PH_DIGIT;
					end
				end
				PH_DIGIT: begin
					gen     = 1'b1;
					phase_d = PH_PLAIN;
					held_d  = '0;
					if (dec == CH_NUL) begin
						cmd.term = 1'b1;
						drop_d   = !in_last;
					end else begin
						cmd.n_data = 2'd1;
						cmd.b0     = dec;
						cmd.term   = in_last;
					end
				end
				default: begin
					phase_d = PH_PLAIN;
					if (in_byte == CH_PERCENT) begin
						if (in_last) begin
							gen        = 1'b1;
							cmd.n_data = 2'd1;
							cmd.b0     = CH_PERCENT;
							cmd.term   = 1'b1;
						end else begin
							phase_d = PH_PCT;
						end
					end else if (in_byte == CH_NUL) begin
						gen      = 1'b1;
						cmd.term = 1'b1;
						drop_d   = !in_last;
					end else begin
						gen        = 1'b1;
						cmd.n_data = 2'd1;
						cmd.b0     = plain_map(in_byte);
						cmd.term   = in_last;
					end
				end
			endcase
		end
	end

	assign push = accept && gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			held_q  <= '0;
			drop_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			drop_q  <= drop_d;
		end
	end

endmodule

[hdl/upd_queue.sv]
// ----------------------------------------------------------------------------
// upd_queue
// Small command queue between the front and the back part.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  upd_cmd_t   wr_cmd,
	input  logic       pop,
	output upd_cmd_t   head,
	output upd_qstat_t stat
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	upd_cmd_t          mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign head            = mem_q[rd_ptr_q];
	assign stat.full       = (count_q == CntW'(QueueDepth));
	assign stat.head_valid = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

[hdl/upd_back.sv]
// ----------------------------------------------------------------------------
// upd_back
// Plays out each queued command one byte per cycle into the output register, unless m_tready stalls it.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  upd_cmd_t   head,
	input  logic       head_valid,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [1:0] idx_q;
	logic [1:0] total;
	logic       load;
	logic [7:0] cur_byte;
	logic       cur_last;

	assign total = head.n_data + {1'b0, head.term};
	assign load  = head_valid && (!m_tvalid || m_tready);
	assign pop   = load && (idx_q == total - 2'd1);

	always_comb begin
		if (idx_q < head.n_data) begin
			cur_byte = (idx_q == 2'd0) ? head.b0 : head.b1;
			cur_last = 1'b0;
		end else begin
			cur_byte = CH_NUL;
			cur_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			m_tvalid <= 1'b1;
			idx_q    <= pop ? 2'd0 : idx_q + 2'd1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= cur_byte;
			m_tlast <= cur_last;
		end
	end

endmodule
